/* hw/rtl/jsu_pkg.sv */
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types and constants for the JSON string unescaper.
// ----------------------------------------------------------------------------
package jsu_pkg;

    localparam int QDEPTH     = 4;
    localparam int QAW        = $clog2(QDEPTH);
    localparam int WIN_DEPTH  = 12;
    localparam int CNT_W      = $clog2(WIN_DEPTH + 1);

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_U      = 8'h75;

    // classified input byte
    typedef struct packed {
        logic [7:0] data;
        logic [3:0] nib;
        logic       is_hex;
        logic       is_bslash;
        logic       is_u;
        logic       last;
    } entry_t;

    typedef enum logic [1:0] {
        BK_RESOLVE,
        BK_EMIT,
        BK_FINISH
    } back_state_t;

endpackage

/* hw/rtl/json_string_unescape_utf8.sv */
// ----------------------------------------------------------------------------
// json_string_unescape_utf8
// Unescapes a JSON string body byte stream and emits UTF-8 bytes.
//
// Channel  Dir  tdata            tuser       tlast
// s_axis   in   [7:0] in_byte    -           in_last
// m_axis   out  [7:0] out_byte   [0] valid   out_last
//
// The back end loads a byte into the window only when no token at its head
// can yet be resolved; further UTF-8 bytes of a token go out one at a time, and
// an end of string whose last byte emitted nothing first flushes the held byte.
// aresetn (synchronous, active low) empties the queue, window and output.
// A stalled m_axis holds the back end; the 4-entry queue then fills and
// s_axis_tready falls.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8 (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
    output logic        m_axis_tuser,   // [0] out_valid
    output logic        m_axis_tlast
);

    logic               push_valid, push_ready;
    jsu_pkg::entry_t    push_entry;
    logic               pop_valid, pop_ready;
    jsu_pkg::entry_t    pop_entry;

    jsu_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_entry    (push_entry)
    );

    jsu_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    jsu_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .pop_valid     (pop_valid),
        .pop_ready     (pop_ready),
        .pop_entry     (pop_entry),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

/* hw/rtl/jsu_front.sv */
// ----------------------------------------------------------------------------
// jsu_front
// Accepts input transfers and tags each byte with its hex value and class.
// ----------------------------------------------------------------------------
module jsu_front (
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [7:0]         s_axis_tdata,   // [7:0] in_byte
    input  logic               s_axis_tlast,
    output logic               push_valid,
    input  logic               push_ready,
    output jsu_pkg::entry_t    push_entry
);

    logic [7:0] b;
    logic [3:0] nib;
    logic       hex;

    assign b = s_axis_tdata;

    always_comb begin
        nib = 4'd0;
        hex = 1'b0;
        if (b >= 8'h30 && b <= 8'h39) begin
            nib = b[3:0];
            hex = 1'b1;
        end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
            nib = b[3:0] + 4'd9;
            hex = 1'b1;
        end
    end

    always_comb begin
        push_entry.data      = b;
        push_entry.nib       = nib;
        push_entry.is_hex    = hex;
        push_entry.is_bslash = (b == jsu_pkg::CH_BSLASH);
        push_entry.is_u      = (b == jsu_pkg::CH_U);
        push_entry.last      = s_axis_tlast;
    end

    assign push_valid    = s_axis_tvalid;
    assign s_axis_tready = push_ready;

endmodule

/* hw/rtl/jsu_fifo.sv */
// ----------------------------------------------------------------------------
// jsu_fifo
// Short queue of classified bytes between front and back end.
// ----------------------------------------------------------------------------
module jsu_fifo (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push_valid,
    output logic               push_ready,
    input  jsu_pkg::entry_t    push_entry,
    output logic               pop_valid,
    input  logic               pop_ready,
    output jsu_pkg::entry_t    pop_entry
);

    jsu_pkg::entry_t          mem_reg [jsu_pkg::QDEPTH];
    logic [jsu_pkg::QAW:0]    wr_ptr_reg, wr_ptr_next;
    logic [jsu_pkg::QAW:0]    rd_ptr_reg, rd_ptr_next;
    logic                     do_push, do_pop;

    assign push_ready = !((wr_ptr_reg[jsu_pkg::QAW] != rd_ptr_reg[jsu_pkg::QAW]) &&
                          (wr_ptr_reg[jsu_pkg::QAW-1:0] == rd_ptr_reg[jsu_pkg::QAW-1:0]));
    assign pop_valid  = (wr_ptr_reg != rd_ptr_reg);
    assign pop_entry  = mem_reg[rd_ptr_reg[jsu_pkg::QAW-1:0]];

    assign do_push = push_valid && push_ready;
    assign do_pop  = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg[jsu_pkg::QAW-1:0]] <= push_entry;
        end
    end

endmodule

/* hw/rtl/jsu_back.sv */
// ----------------------------------------------------------------------------
// jsu_back
// Holds the escape window, resolves one token per cycle when not stalled, encodes
// UTF-8 and drives the output register with one result of lookahead for tlast.
// ----------------------------------------------------------------------------
module jsu_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               pop_valid,
    output logic               pop_ready,
    input  jsu_pkg::entry_t    pop_entry,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [7:0]         m_axis_tdata,   // [7:0] out_byte
    output logic               m_axis_tuser,   // [0] out_valid
    output logic               m_axis_tlast
);

    typedef enum logic [2:0] {
        DROP_NONE,
        DROP_1,
        DROP_2,
        DROP_6,
        DROP_ALL
    } drop_t;

    typedef struct packed {
        logic [2:0]  len;
        logic [31:0] bytes;
    } utf8_t;

    localparam logic [15:0] CP_REPL = 16'hFFFD;

    function automatic logic [7:0] esc_map(input logic [7:0] e);
        logic [7:0] r;
        case (e)
            8'h62:   r = 8'h08;
            8'h66:   r = 8'h0C;
            8'h6E:   r = 8'h0A;
            8'h72:   r = 8'h0D;
            8'h74:   r = 8'h09;
            default: r = e;
        endcase
        return r;
    endfunction

    function automatic utf8_t utf8_enc(input logic [20:0] cp);
        utf8_t u;
        u.bytes = '0;
        if (cp <= 21'h7F) begin
            u.len   = 3'd1;
            u.bytes = {24'd0, 1'b0, cp[6:0]};
        end else if (cp <= 21'h7FF) begin
            u.len   = 3'd2;
            u.bytes = {16'd0, 2'b10, cp[5:0], 3'b110, cp[10:6]};
        end else if (cp <= 21'hFFFF) begin
            u.len   = 3'd3;
            u.bytes = {8'd0, 2'b10, cp[5:0], 2'b10, cp[11:6], 4'b1110, cp[15:12]};
        end else begin
            u.len   = 3'd4;
            u.bytes = {2'b10, cp[5:0], 2'b10, cp[11:6], 2'b10, cp[17:12],
                       5'b11110, cp[20:18]};
        end
        return u;
    endfunction

    jsu_pkg::entry_t            win_reg [jsu_pkg::WIN_DEPTH];
    jsu_pkg::entry_t            win_next [jsu_pkg::WIN_DEPTH];
    logic [jsu_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic                       fin_reg, fin_next;
    logic                       fin_emit_reg, fin_emit_next;
    jsu_pkg::back_state_t       state_reg, state_next;
    logic [23:0]                emit_reg, emit_next;
    logic [1:0]                 left_reg, left_next;
    logic [7:0]                 pend_reg, pend_next;
    logic                       pend_vld_reg, pend_vld_next;
    logic                       tvalid_reg, tvalid_next;
    logic [7:0]                 tdata_reg, tdata_next;
    logic                       tuser_reg, tuser_next;
    logic                       tlast_reg, tlast_next;

    logic                       out_free;
    logic                       hex_a, hex_b, is_hi, is_lo, pair_ok;
    logic [15:0]                cp_a, cp_b;
    logic [20:0]                cp_full;
    logic                       dec_done;
    drop_t                      dec_drop;
    logic                       dec_use_cp;
    logic [20:0]                dec_cp;
    logic [7:0]                 dec_byte;
    utf8_t                      enc;
    logic [2:0]                 em_len;
    logic [31:0]                em_bytes;

    assign out_free = !tvalid_reg || m_axis_tready;

    assign hex_a   = win_reg[2].is_hex && win_reg[3].is_hex &&
                     win_reg[4].is_hex && win_reg[5].is_hex;
    assign hex_b   = win_reg[8].is_hex && win_reg[9].is_hex &&
                     win_reg[10].is_hex && win_reg[11].is_hex;
    assign cp_a    = {win_reg[2].nib, win_reg[3].nib, win_reg[4].nib, win_reg[5].nib};
    assign cp_b    = {win_reg[8].nib, win_reg[9].nib, win_reg[10].nib, win_reg[11].nib};
    assign is_hi   = (cp_a[15:10] == 6'b110110);
    assign is_lo   = (cp_a[15:10] == 6'b110111);
    assign pair_ok = win_reg[6].is_bslash && win_reg[7].is_u && hex_b &&
                     (cp_b[15:10] == 6'b110111);
    assign cp_full = 21'h10000 + 21'({cp_a[9:0], cp_b[9:0]});

    // token decode at the window head
    always_comb begin
        dec_done   = 1'b0;
        dec_drop   = DROP_NONE;
        dec_use_cp = 1'b0;
        dec_cp     = '0;
        dec_byte   = '0;
        if (cnt_reg == '0) begin
            dec_done = 1'b1;
        end else if (!win_reg[0].is_bslash) begin
            dec_byte = win_reg[0].data;
            dec_drop = DROP_1;
        end else if (cnt_reg < jsu_pkg::CNT_W'(2)) begin
            dec_done = 1'b1;
        end else if (!win_reg[1].is_u) begin
            dec_byte = esc_map(win_reg[1].data);
            dec_drop = DROP_2;
        end else if (cnt_reg < jsu_pkg::CNT_W'(6)) begin
            dec_done = 1'b1;
        end else if (!hex_a) begin
            dec_drop = DROP_2;
        end else if (is_hi) begin
            if (cnt_reg < jsu_pkg::CNT_W'(jsu_pkg::WIN_DEPTH) && !fin_reg) begin
                dec_done = 1'b1;
            end else if (cnt_reg == jsu_pkg::CNT_W'(jsu_pkg::WIN_DEPTH) && pair_ok) begin
                dec_use_cp = 1'b1;
                dec_cp     = cp_full;
                dec_drop   = DROP_ALL;
            end else begin
                dec_use_cp = 1'b1;
                dec_cp     = 21'(CP_REPL);
                dec_drop   = DROP_6;
            end
        end else if (is_lo) begin
            dec_use_cp = 1'b1;
            dec_cp     = 21'(CP_REPL);
            dec_drop   = DROP_6;
        end else begin
            dec_use_cp = 1'b1;
            dec_cp     = 21'(cp_a);
            dec_drop   = DROP_6;
        end
    end

    always_comb begin
        enc = utf8_enc(dec_cp);
        if (dec_use_cp) begin
            em_len   = enc.len;
            em_bytes = enc.bytes;
        end else if (dec_drop == DROP_1 || (dec_drop == DROP_2 && !win_reg[1].is_u)) begin
            em_len   = 3'd1;
            em_bytes = {24'd0, dec_byte};
        end else begin
            em_len   = 3'd0;
            em_bytes = '0;
        end
    end

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        fin_next      = fin_reg;
        fin_emit_next = fin_emit_reg;
        emit_next     = emit_reg;
        left_next     = left_reg;
        pend_next     = pend_reg;
        pend_vld_next = pend_vld_reg;
        tvalid_next   = tvalid_reg && !m_axis_tready;
        tdata_next    = tdata_reg;
        tuser_next    = tuser_reg;
        tlast_next    = tlast_reg;
        pop_ready     = 1'b0;
        for (int i = 0; i < jsu_pkg::WIN_DEPTH; i++) begin
            win_next[i] = win_reg[i];
        end

        case (state_reg)
            jsu_pkg::BK_RESOLVE: begin
                if (dec_done) begin
                    if (fin_reg) begin
                        state_next = jsu_pkg::BK_FINISH;
                    end else if (pop_valid) begin
                        pop_ready = 1'b1;
                        for (int i = 0; i < jsu_pkg::WIN_DEPTH; i++) begin
                            if (cnt_reg == jsu_pkg::CNT_W'(i)) begin
                                win_next[i] = pop_entry;
                            end
                        end
                        cnt_next      = cnt_reg + 1'b1;
                        fin_next      = pop_entry.last;
                        fin_emit_next = 1'b0;
                    end
                end else if (!(em_len != 3'd0 && pend_vld_reg && !out_free)) begin
                    for (int i = 0; i < jsu_pkg::WIN_DEPTH; i++) begin
                        case (dec_drop)
                            DROP_1: if (i + 1 < jsu_pkg::WIN_DEPTH) win_next[i] = win_reg[i + 1];
                            DROP_2: if (i + 2 < jsu_pkg::WIN_DEPTH) win_next[i] = win_reg[i + 2];
                            DROP_6: if (i + 6 < jsu_pkg::WIN_DEPTH) win_next[i] = win_reg[i + 6];
                            default: win_next[i] = win_reg[i];
                        endcase
                    end
                    case (dec_drop)
                        DROP_1:   cnt_next = cnt_reg - jsu_pkg::CNT_W'(1);
                        DROP_2:   cnt_next = cnt_reg - jsu_pkg::CNT_W'(2);
                        DROP_6:   cnt_next = cnt_reg - jsu_pkg::CNT_W'(6);
                        DROP_ALL: cnt_next = '0;
                        default:  cnt_next = cnt_reg;
                    endcase
                    if (em_len != 3'd0) begin
                        if (pend_vld_reg) begin
                            tvalid_next = 1'b1;
                            tdata_next  = pend_reg;
                            tuser_next  = 1'b1;
                            tlast_next  = 1'b0;
                        end
                        if (fin_reg) begin
                            fin_emit_next = 1'b1;
                        end
                        pend_next     = em_bytes[7:0];
                        pend_vld_next = 1'b1;
                        if (em_len > 3'd1) begin
                            emit_next  = em_bytes[31:8];
                            left_next  = 2'(em_len - 3'd1);
                            state_next = jsu_pkg::BK_EMIT;
                        end
                    end
                end
            end
            jsu_pkg::BK_EMIT: begin
                if (out_free) begin
                    tvalid_next = 1'b1;
                    tdata_next  = pend_reg;
                    tuser_next  = 1'b1;
                    tlast_next  = 1'b0;
                    pend_next   = emit_reg[7:0];
                    emit_next   = {8'd0, emit_reg[23:8]};
                    left_next   = left_reg - 2'd1;
                    if (left_reg == 2'd1) begin
                        state_next = jsu_pkg::BK_RESOLVE;
                    end
                end
            end
            jsu_pkg::BK_FINISH: begin
                if (out_free) begin
                    tvalid_next = 1'b1;
                    if (pend_vld_reg && !fin_emit_reg) begin
                        // byte held from before the last transfer goes out first,
                        // then the empty end marker
                        tdata_next    = pend_reg;
                        tuser_next    = 1'b1;
                        tlast_next    = 1'b0;
                        pend_vld_next = 1'b0;
                    end else begin
                        tdata_next    = pend_vld_reg ? pend_reg : 8'd0;
                        tuser_next    = pend_vld_reg;
                        tlast_next    = 1'b1;
                        pend_vld_next = 1'b0;
                        cnt_next      = '0;
                        fin_next      = 1'b0;
                        fin_emit_next = 1'b0;
                        state_next    = jsu_pkg::BK_RESOLVE;
                    end
                end
            end
            default: begin
                state_next = jsu_pkg::BK_RESOLVE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= jsu_pkg::BK_RESOLVE;
            cnt_reg      <= '0;
            fin_reg      <= 1'b0;
            fin_emit_reg <= 1'b0;
            left_reg     <= '0;
            pend_vld_reg <= 1'b0;
            tvalid_reg   <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            fin_reg      <= fin_next;
            fin_emit_reg <= fin_emit_next;
            left_reg     <= left_next;
            pend_vld_reg <= pend_vld_next;
            tvalid_reg   <= tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        emit_reg  <= emit_next;
        pend_reg  <= pend_next;
        tdata_reg <= tdata_next;
        tuser_reg <= tuser_next;
        tlast_reg <= tlast_next;
        for (int i = 0; i < jsu_pkg::WIN_DEPTH; i++) begin
            win_reg[i] <= win_next[i];
        end
    end

    assign m_axis_tvalid = tvalid_reg;
    assign m_axis_tdata  = tdata_reg;
    assign m_axis_tuser  = tuser_reg;
    assign m_axis_tlast  = tlast_reg;

endmodule
